// ----- hw/rtl/bcec_pkg.sv -----
// shared constants, types and sequencer states for the biconnected edge coloring block
package bcec_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;
  localparam int SLOT_COUNT   = 2 * MAX_EDGES;
  localparam int VW           = $clog2(MAX_VERTICES);   // vertex number width
  localparam int EW           = $clog2(MAX_EDGES);      // edge number width
  localparam int SW           = $clog2(SLOT_COUNT);     // slot address width
  localparam int PW           = SW + 1;                 // slot pointer, top bit = end of list
  localparam int CW           = EW + 1;                 // color and edge count width
  localparam int NW           = VW + 1;                 // vertex count width

  localparam logic [PW-1:0] NO_SLOT   = PW'(SLOT_COUNT);
  localparam logic [NW-1:0] VERT_MAX  = NW'(MAX_VERTICES);
  localparam logic [CW-1:0] EDGE_MAX  = CW'(MAX_EDGES);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  // one frame of the depth-first walk stack
  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          has_parent;
    logic [VW-1:0] parent;
    logic [PW-1:0] cursor;
    logic [PW-1:0] head;
    logic [VW-1:0] disc;
    logic [VW-1:0] low;
    logic [CW-1:0] color;
  } frame_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_LK_RD,
    S_LK_WR,
    S_LK_TAIL,
    S_LK_NEXT,
    S_SWEEP,
    S_ROOT,
    S_RPUSH,
    S_SCAN,
    S_NB,
    S_RESTORE,
    S_DEC,
    S_CB_FETCH,
    S_CB_CHECK,
    S_PUSH2,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/biconnected_edge_coloring_top.sv -----
// biconnected component edge coloring: edge loading, two depth-first walks, color reads
//
// Requests are taken one at a time, and not while an answer waits at the output. A color read
// is answered from S_RD with a registered result. An edge load within capacity whose vertices
// are both in range makes two list appends into the adjacency memories. The load flagged last
// then clears the color of every loaded edge and runs two depth-first walks over the
// single-ported slot memory, scanning each adjacency slot, entering each root and leaving each
// vertex; for every tree or back edge colored, the coloring walk also scans the whole slot
// list of the vertex. The component count comes out when both walks end. The top of the walk
// stack lives in registers, the rest in a stack memory; the adjacency lists, per-vertex values
// and edge colors sit in synchronous memories with registered reads.
module biconnected_edge_coloring_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bcec_pkg::NW-1:0]  cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic [bcec_pkg::VW-1:0]  in_vertex_a,
  input  logic [bcec_pkg::VW-1:0]  in_vertex_b,
  input  logic                     in_last_edge,
  input  logic [bcec_pkg::EW-1:0]  in_edge_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic [bcec_pkg::CW-1:0]  out_result_value
);
  import bcec_pkg::*;

  // control and walk registers
  state_t                  state_r, state_nxt;
  logic [NW-1:0]           vcount_r, vcount_nxt;
  logic                    run_done_r, run_done_nxt;
  logic [CW-1:0]           edges_r, edges_nxt;
  logic [CW-1:0]           ccount_r, ccount_nxt;
  logic [NW-1:0]           time_r, time_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] hvalid_r, hvalid_nxt;
  frame_t                  tos_r, tos_nxt;
  logic [NW-1:0]           sp_r, sp_nxt;
  logic [NW-1:0]           root_r, root_nxt;
  logic                    pass_r, pass_nxt;
  logic [VW-1:0]           lk_owner_r, lk_owner_nxt;
  logic [VW-1:0]           lk_other_r, lk_other_nxt;
  logic [SW-1:0]           lk_slot_r, lk_slot_nxt;
  logic                    lk_second_r, lk_second_nxt;
  logic                    last_r, last_nxt;
  logic [CW-1:0]           sw_r, sw_nxt;
  logic [VW-1:0]           w_r, w_nxt;
  logic [PW-1:0]           cb_s_r, cb_s_nxt;
  logic [CW-1:0]           c_r, c_nxt;
  logic                    push_pend_r, push_pend_nxt;
  logic [PW-1:0]           wh_r, wh_nxt;
  logic [VW-1:0]           wd_r, wd_nxt;
  logic [VW-1:0]           child_low_r, child_low_nxt;
  logic                    rd_ok_r, rd_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [CW-1:0]           out_value_r, out_value_nxt;

  // memories
  logic [VW-1:0] nb_mem   [SLOT_COUNT];
  logic [PW-1:0] nxt_mem  [SLOT_COUNT];
  logic [PW-1:0] head_mem [MAX_VERTICES];
  logic [PW-1:0] tail_mem [MAX_VERTICES];
  logic [VW-1:0] disc_mem [MAX_VERTICES];
  logic [VW-1:0] low_mem  [MAX_VERTICES];
  frame_t        stk_mem  [MAX_VERTICES];
  logic [CW-1:0] col_mem  [MAX_EDGES];

  logic [SW-1:0] slot_ra;
  logic [VW-1:0] nb_q;
  logic [PW-1:0] nxt_q;
  logic          nb_we;
  logic          nxt_we;
  logic [SW-1:0] nxt_wa;
  logic [PW-1:0] nxt_wd;
  logic [VW-1:0] vr_addr;
  logic [PW-1:0] head_q, tail_q;
  logic          head_we, tail_we;
  logic [VW-1:0] disc_q, low_q;
  logic          disc_we, low_we;
  logic [VW-1:0] disc_wa, low_wa;
  logic [VW-1:0] disc_wd, low_wd;
  logic [VW-1:0] stk_ra;
  frame_t        stk_q;
  logic          stk_we;
  logic [VW-1:0] stk_wa;
  logic [CW-1:0] col_q;
  logic          col_we;
  logic [EW-1:0] col_wa;
  logic [CW-1:0] col_wd;

  logic [NW-1:0] gsize;
  logic [NW-1:0] sp_m1, sp_m2;
  logic [CW-1:0] load_e;
  logic [PW-1:0] head_eff;
  logic          in_acc;

  assign gsize    = (vcount_r > VERT_MAX) ? VERT_MAX : vcount_r;
  assign sp_m1    = sp_r - NW'(1);
  assign sp_m2    = sp_r - NW'(2);
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign load_e   = run_done_r ? '0 : edges_r;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_value_r;

  // read addresses
  assign slot_ra = (state_r == S_CB_FETCH) ? cb_s_r[SW-1:0] : tos_r.cursor[SW-1:0];
  assign vr_addr = (state_r == S_ROOT) ? root_r[VW-1:0] : nb_q;
  assign stk_ra  = sp_m2[VW-1:0];
  assign stk_wa  = sp_m1[VW-1:0];

  // slot memories
  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[lk_slot_r] <= lk_other_r;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nb_q  <= nb_mem[slot_ra];
    nxt_q <= nxt_mem[slot_ra];
  end

  // per-vertex memories
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[lk_owner_r] <= {1'b0, lk_slot_r};
    end
    if (tail_we) begin
      tail_mem[lk_owner_r] <= {1'b0, lk_slot_r};
    end
    if (disc_we) begin
      disc_mem[disc_wa] <= disc_wd;
    end
    if (low_we) begin
      low_mem[low_wa] <= low_wd;
    end
    head_q <= head_mem[vr_addr];
    tail_q <= tail_mem[lk_owner_r];
    disc_q <= disc_mem[vr_addr];
    low_q  <= low_mem[vr_addr];
  end

  // walk stack and edge colors
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= tos_r;
    end
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    stk_q <= stk_mem[stk_ra];
    col_q <= col_mem[in_edge_index];
  end

  assign head_eff = (state_r == S_RPUSH) ?
                    (hvalid_r[root_r[VW-1:0]] ? head_q : NO_SLOT) :
                    (hvalid_r[w_r] ? head_q : NO_SLOT);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= VERT_MAX;
      run_done_r  <= 1'b0;
      edges_r     <= '0;
      ccount_r    <= '0;
      time_r      <= '0;
      visited_r   <= '0;
      hvalid_r    <= '0;
      sp_r        <= '0;
      root_r      <= '0;
      pass_r      <= 1'b0;
      lk_second_r <= 1'b0;
      last_r      <= 1'b0;
      push_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      run_done_r  <= run_done_nxt;
      edges_r     <= edges_nxt;
      ccount_r    <= ccount_nxt;
      time_r      <= time_nxt;
      visited_r   <= visited_nxt;
      hvalid_r    <= hvalid_nxt;
      sp_r        <= sp_nxt;
      root_r      <= root_nxt;
      pass_r      <= pass_nxt;
      lk_second_r <= lk_second_nxt;
      last_r      <= last_nxt;
      push_pend_r <= push_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tos_r       <= tos_nxt;
    lk_owner_r  <= lk_owner_nxt;
    lk_other_r  <= lk_other_nxt;
    lk_slot_r   <= lk_slot_nxt;
    sw_r        <= sw_nxt;
    w_r         <= w_nxt;
    cb_s_r      <= cb_s_nxt;
    c_r         <= c_nxt;
    wh_r        <= wh_nxt;
    wd_r        <= wd_nxt;
    child_low_r <= child_low_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = cfg_wr_en ? cfg_wr_data : vcount_r;
    run_done_nxt  = run_done_r;
    edges_nxt     = edges_r;
    ccount_nxt    = ccount_r;
    time_nxt      = time_r;
    visited_nxt   = visited_r;
    hvalid_nxt    = hvalid_r;
    tos_nxt       = tos_r;
    sp_nxt        = sp_r;
    root_nxt      = root_r;
    pass_nxt      = pass_r;
    lk_owner_nxt  = lk_owner_r;
    lk_other_nxt  = lk_other_r;
    lk_slot_nxt   = lk_slot_r;
    lk_second_nxt = lk_second_r;
    last_nxt      = last_r;
    sw_nxt        = sw_r;
    w_nxt         = w_r;
    cb_s_nxt      = cb_s_r;
    c_nxt         = c_r;
    push_pend_nxt = push_pend_r;
    wh_nxt        = wh_r;
    wd_nxt        = wd_r;
    child_low_nxt = child_low_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;

    nb_we   = 1'b0;
    nxt_we  = 1'b0;
    nxt_wa  = lk_slot_r;
    nxt_wd  = NO_SLOT;
    head_we = 1'b0;
    tail_we = 1'b0;
    disc_we = 1'b0;
    disc_wa = tos_r.vertex;
    disc_wd = time_r[VW-1:0];
    low_we  = 1'b0;
    low_wa  = tos_r.vertex;
    low_wd  = tos_r.low;
    stk_we  = 1'b0;
    col_we  = 1'b0;
    col_wa  = sw_r[EW-1:0];
    col_wd  = '0;

    case (state_r)
      // take a request
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_READ) begin
            rd_ok_nxt = run_done_r && ({1'b0, in_edge_index} < edges_r);
            state_nxt = S_RD;
          end else begin
            if (run_done_r) begin
              run_done_nxt = 1'b0;
              hvalid_nxt   = '0;
              visited_nxt  = '0;
              ccount_nxt   = '0;
              time_nxt     = '0;
              edges_nxt    = '0;
            end
            last_nxt  = in_last_edge;
            sw_nxt    = '0;
            state_nxt = in_last_edge ? S_SWEEP : S_IDLE;
            if (load_e < EDGE_MAX) begin
              edges_nxt = load_e + CW'(1);
              if (({1'b0, in_vertex_a} < gsize) && ({1'b0, in_vertex_b} < gsize)) begin
                lk_owner_nxt  = in_vertex_a;
                lk_other_nxt  = in_vertex_b;
                lk_slot_nxt   = {load_e[EW-1:0], 1'b0};
                lk_second_nxt = 1'b0;
                state_nxt     = S_LK_RD;
              end
            end
          end
        end
      end

      // color read answer
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_COLOR;
        out_value_nxt = rd_ok_r ? col_q : '0;
        state_nxt     = S_IDLE;
      end

      // append a slot to the owner's list
      S_LK_RD: begin
        state_nxt = S_LK_WR;
      end

      S_LK_WR: begin
        nb_we   = 1'b1;
        nxt_we  = 1'b1;
        tail_we = 1'b1;
        if (hvalid_r[lk_owner_r]) begin
          state_nxt = S_LK_TAIL;
        end else begin
          head_we                = 1'b1;
          hvalid_nxt[lk_owner_r] = 1'b1;
          state_nxt              = S_LK_NEXT;
        end
      end

      S_LK_TAIL: begin
        nxt_we    = 1'b1;
        nxt_wa    = tail_q[SW-1:0];
        nxt_wd    = {1'b0, lk_slot_r};
        state_nxt = S_LK_NEXT;
      end

      S_LK_NEXT: begin
        if (!lk_second_r) begin
          lk_owner_nxt  = lk_other_r;
          lk_other_nxt  = lk_owner_r;
          lk_slot_nxt   = {lk_slot_r[SW-1:1], 1'b1};
          lk_second_nxt = 1'b1;
          state_nxt     = S_LK_RD;
        end else begin
          state_nxt = last_r ? S_SWEEP : S_IDLE;
        end
      end

      // clear colors of the loaded edges
      S_SWEEP: begin
        if (sw_r == edges_r) begin
          visited_nxt = '0;
          pass_nxt    = 1'b0;
          root_nxt    = '0;
          state_nxt   = S_ROOT;
        end else begin
          col_we    = 1'b1;
          col_wa    = sw_r[EW-1:0];
          col_wd    = '0;
          sw_nxt    = sw_r + CW'(1);
        end
      end

      // next unvisited root, or next pass, or the end of both walks
      S_ROOT: begin
        if (root_r == gsize) begin
          if (!pass_r) begin
            pass_nxt    = 1'b1;
            root_nxt    = '0;
            visited_nxt = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (visited_r[root_r[VW-1:0]]) begin
          root_nxt = root_r + NW'(1);
        end else begin
          state_nxt = S_RPUSH;
        end
      end

      S_RPUSH: begin
        tos_nxt.vertex     = root_r[VW-1:0];
        tos_nxt.has_parent = 1'b0;
        tos_nxt.parent     = '0;
        tos_nxt.cursor     = head_eff;
        tos_nxt.head       = head_eff;
        tos_nxt.disc       = pass_r ? disc_q : time_r[VW-1:0];
        tos_nxt.low        = time_r[VW-1:0];
        tos_nxt.color      = ccount_r;
        if (!pass_r) begin
          disc_we  = 1'b1;
          disc_wa  = root_r[VW-1:0];
          time_nxt = time_r + NW'(1);
        end
        visited_nxt[root_r[VW-1:0]] = 1'b1;
        sp_nxt    = NW'(1);
        state_nxt = S_SCAN;
      end

      // scan the top frame, or pop it at the end of its list
      S_SCAN: begin
        if (tos_r.cursor[SW]) begin
          if (!pass_r) begin
            low_we = 1'b1;
          end
          child_low_nxt = tos_r.low;
          sp_nxt        = sp_m1;
          state_nxt     = (sp_r == NW'(1)) ? S_ROOT : S_RESTORE;
        end else begin
          state_nxt = S_NB;
        end
      end

      S_NB: begin
        tos_nxt.cursor = nxt_q;
        w_nxt          = nb_q;
        if (tos_r.has_parent && (nb_q == tos_r.parent)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DEC;
        end
      end

      S_RESTORE: begin
        tos_nxt = stk_q;
        if (!pass_r && (child_low_r < stk_q.low)) begin
          tos_nxt.low = child_low_r;
        end
        state_nxt = S_SCAN;
      end

      // decide on the neighbor
      S_DEC: begin
        state_nxt = S_SCAN;
        if (!pass_r) begin
          if (visited_r[w_r]) begin
            if (disc_q < tos_r.low) begin
              tos_nxt.low = disc_q;
            end
          end else begin
            stk_we             = 1'b1;
            tos_nxt.vertex     = w_r;
            tos_nxt.has_parent = 1'b1;
            tos_nxt.parent     = tos_r.vertex;
            tos_nxt.cursor     = head_eff;
            tos_nxt.head       = head_eff;
            tos_nxt.disc       = time_r[VW-1:0];
            tos_nxt.low        = time_r[VW-1:0];
            tos_nxt.color      = '0;
            disc_we            = 1'b1;
            disc_wa            = w_r;
            time_nxt           = time_r + NW'(1);
            visited_nxt[w_r]   = 1'b1;
            sp_nxt             = sp_r + NW'(1);
          end
        end else begin
          if (!visited_r[w_r]) begin
            if (low_q >= tos_r.disc) begin
              ccount_nxt = ccount_r + CW'(1);
              c_nxt      = ccount_r + CW'(1);
            end else begin
              c_nxt = tos_r.color;
            end
            push_pend_nxt = 1'b1;
            wh_nxt        = head_eff;
            wd_nxt        = disc_q;
            cb_s_nxt      = tos_r.head;
            state_nxt     = S_CB_FETCH;
          end else if (disc_q < tos_r.disc) begin
            c_nxt         = tos_r.color;
            push_pend_nxt = 1'b0;
            cb_s_nxt      = tos_r.head;
            state_nxt     = S_CB_FETCH;
          end
        end
      end

      // color every edge between the top vertex and the neighbor
      S_CB_FETCH: begin
        if (cb_s_r[SW]) begin
          state_nxt = push_pend_r ? S_PUSH2 : S_SCAN;
        end else begin
          state_nxt = S_CB_CHECK;
        end
      end

      S_CB_CHECK: begin
        if (nb_q == w_r) begin
          col_we = 1'b1;
          col_wa = cb_s_r[SW-1:1];
          col_wd = c_r;
        end
        cb_s_nxt  = nxt_q;
        state_nxt = S_CB_FETCH;
      end

      S_PUSH2: begin
        stk_we             = 1'b1;
        tos_nxt.vertex     = w_r;
        tos_nxt.has_parent = 1'b1;
        tos_nxt.parent     = tos_r.vertex;
        tos_nxt.cursor     = wh_r;
        tos_nxt.head       = wh_r;
        tos_nxt.disc       = wd_r;
        tos_nxt.low        = '0;
        tos_nxt.color      = c_r;
        visited_nxt[w_r]   = 1'b1;
        sp_nxt             = sp_r + NW'(1);
        state_nxt          = S_SCAN;
      end

      // component count answer
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_COUNT;
        out_value_nxt = ccount_r;
        run_done_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // stack never deeper than the maximum vertex count
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= VERT_MAX) else $error("walk stack overflow");

  // a frame is on top whenever the top is scanned
  a_scan_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_NB || state_r == S_DEC) |-> (sp_r != '0))
    else $error("scan with empty stack");

  // loaded edge count stays within capacity
  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= EDGE_MAX) else $error("edge count beyond capacity");

  // a count answer follows only from the end of the walks
  a_done_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (out_valid_r && out_kind_r == KIND_COUNT && run_done_r))
    else $error("count answer missing");

  // discovery times fit the vertex range
  a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
    time_r <= VERT_MAX) else $error("time counter overflow");
`endif

endmodule
